[sv/fk3_pkg.sv]
// Shared types and constants for the planar three-link forward kinematics block.
// Holds the CORDIC word format, the arctangent table, quadrant and register codes.
// No dependencies.
package fk3_pkg;

   localparam int LINKS         = 3;
   localparam int CORDIC_STEPS  = 24;
   localparam int CORDIC_WIDTH  = 32;
   localparam int FRAC_BITS     = 30;
   localparam int POS_WIDTH     = 19;
   localparam int POS_MAX       = 262143;
   localparam int POS_MIN       = -262144;

   typedef logic signed [CORDIC_WIDTH-1:0] cordic_word_type;

   // Gain-compensated start vector, Q30
   localparam cordic_word_type CORDIC_GAIN_Q30 = 32'sd652032874;
   // Half a quadrant in 2^-32 turn units, used to pick the nearest quadrant
   localparam logic [CORDIC_WIDTH-1:0] HALF_QUADRANT = 32'h2000_0000;
   localparam cordic_word_type RESIDUAL_LIMIT = 32'sd536870912;

   typedef enum logic [1:0] {
      QUAD_EAST  = 2'd0,
      QUAD_NORTH = 2'd1,
      QUAD_WEST  = 2'd2,
      QUAD_SOUTH = 2'd3
   } quadrant_type;

   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_FIRST_LINK  = 2'd0;
   localparam csr_addr_type CSR_SECOND_LINK = 2'd1;
   localparam csr_addr_type CSR_THIRD_LINK  = 2'd2;

   typedef struct packed {
      cordic_word_type x;
      cordic_word_type y;
      cordic_word_type z;
      quadrant_type    q;
   } lane_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic cordic_word_type arc_angle(input int step);
      cordic_word_type a;
      case (step)
         0:       a = 32'sd536870912;
         1:       a = 32'sd316933406;
         2:       a = 32'sd167458907;
         3:       a = 32'sd85004756;
         4:       a = 32'sd42667331;
         5:       a = 32'sd21354465;
         6:       a = 32'sd10679838;
         7:       a = 32'sd5340245;
         8:       a = 32'sd2670163;
         9:       a = 32'sd1335087;
         10:      a = 32'sd667544;
         11:      a = 32'sd333772;
         12:      a = 32'sd166886;
         13:      a = 32'sd83443;
         14:      a = 32'sd41722;
         15:      a = 32'sd20861;
         16:      a = 32'sd10430;
         17:      a = 32'sd5215;
         18:      a = 32'sd2608;
         19:      a = 32'sd1304;
         20:      a = 32'sd652;
         21:      a = 32'sd326;
         22:      a = 32'sd163;
         23:      a = 32'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

[sv/planar_three_link_forward_kinematics_top.sv]
// Top level of the planar three-link arm forward kinematics block.
// Holds the link length registers; instantiates fk3_prep, fk3_cordic and fk3_combine.
// Depends on fk3_pkg.
//
// A beat on req_ carries three relative joint angles in binary angle units
// (2^ANGLE_WIDTH per turn); rsp_ gives the tool position rounded to whole length
// units and clamped to 19 bits, and the wrapped heading. One beat is taken every
// cycle while req_stall is low. The path is 1 seed stage, 24 CORDIC micro-rotation
// stages, then restore, multiply, sum and result register. Each stage holds its own
// valid bit, so a stall on rsp_ is absorbed by empty stages before req_stall rises.
// Link lengths reset to zero and are written through csr_ (index 0 to 2, others
// ignored); the user must write them only while no beat is in flight (not enforced).
module planar_three_link_forward_kinematics_top #(
   parameter int ANGLE_WIDTH  = 16,
   parameter int LENGTH_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ANGLE_WIDTH-1:0]        req_first_joint_angle,
   input  logic signed [ANGLE_WIDTH-1:0]        req_second_joint_angle,
   input  logic signed [ANGLE_WIDTH-1:0]        req_third_joint_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fk3_pkg::POS_WIDTH-1:0] rsp_tool_x,
   output logic signed [fk3_pkg::POS_WIDTH-1:0] rsp_tool_y,
   output logic signed [ANGLE_WIDTH-1:0]        rsp_tool_heading,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  fk3_pkg::csr_addr_type                csr_index,
   input  logic [LENGTH_WIDTH-1:0]              csr_data
);

   logic [LENGTH_WIDTH-1:0] len_ff [fk3_pkg::LINKS];

   logic                   prep_ready;
   logic                   prep_valid;
   fk3_pkg::lane_type      prep_lane [fk3_pkg::LINKS];
   logic [ANGLE_WIDTH-1:0] prep_heading;
   logic                   cordic_ready;
   logic                   cordic_valid;
   fk3_pkg::lane_type      cordic_lane [fk3_pkg::LINKS];
   logic [ANGLE_WIDTH-1:0] cordic_heading;
   logic                   combine_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fk3_pkg::LINKS; i++) begin
            len_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            fk3_pkg::CSR_FIRST_LINK:  len_ff[0] <= csr_data;
            fk3_pkg::CSR_SECOND_LINK: len_ff[1] <= csr_data;
            fk3_pkg::CSR_THIRD_LINK:  len_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = !prep_ready;

   fk3_prep #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (prep_ready),
      .first_angle  (req_first_joint_angle),
      .second_angle (req_second_joint_angle),
      .third_angle  (req_third_joint_angle),
      .out_valid    (prep_valid),
      .out_ready    (cordic_ready),
      .out_lane     (prep_lane),
      .out_heading  (prep_heading)
   );

   fk3_cordic #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (prep_valid),
      .in_ready    (cordic_ready),
      .in_lane     (prep_lane),
      .in_heading  (prep_heading),
      .out_valid   (cordic_valid),
      .out_ready   (combine_ready),
      .out_lane    (cordic_lane),
      .out_heading (cordic_heading)
   );

   fk3_combine #(
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_combine (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (cordic_valid),
      .in_ready         (combine_ready),
      .in_lane          (cordic_lane),
      .in_heading       (cordic_heading),
      .link_length      (len_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tool_x       (rsp_tool_x),
      .rsp_tool_y       (rsp_tool_y),
      .rsp_tool_heading (rsp_tool_heading)
   );

`ifndef SYNTHESIS
   a_unmapped_write_ignored: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index != fk3_pkg::CSR_FIRST_LINK
         && csr_index != fk3_pkg::CSR_SECOND_LINK
         && csr_index != fk3_pkg::CSR_THIRD_LINK |=>
         $stable(len_ff[0]) && $stable(len_ff[1]) && $stable(len_ff[2]))
      else $error("write to an unmapped index changed a link length");
`endif

endmodule

[sv/fk3_prep.sv]
// Input stage: cumulative link angles, nearest-quadrant removal, CORDIC seed.
// Depends on fk3_pkg.
module fk3_prep #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [ANGLE_WIDTH-1:0] first_angle,
   input  logic signed [ANGLE_WIDTH-1:0] second_angle,
   input  logic signed [ANGLE_WIDTH-1:0] third_angle,
   output logic                          out_valid,
   input  logic                          out_ready,
   output fk3_pkg::lane_type             out_lane [fk3_pkg::LINKS],
   output logic [ANGLE_WIDTH-1:0]        out_heading
);

   localparam int CW  = fk3_pkg::CORDIC_WIDTH;
   localparam int PAD = CW - ANGLE_WIDTH;

   logic                   valid_ff;
   fk3_pkg::lane_type      lane_ff [fk3_pkg::LINKS];
   fk3_pkg::lane_type      lane_in [fk3_pkg::LINKS];
   logic [ANGLE_WIDTH-1:0] heading_ff;
   logic [ANGLE_WIDTH-1:0] angle_sum [fk3_pkg::LINKS];
   logic [CW-1:0]          phase [fk3_pkg::LINKS];
   logic [CW-1:0]          rounded [fk3_pkg::LINKS];
   logic [CW-1:0]          resid [fk3_pkg::LINKS];
   fk3_pkg::quadrant_type  quad [fk3_pkg::LINKS];

   always_comb begin
      angle_sum[0] = first_angle;
      angle_sum[1] = angle_sum[0] + second_angle;
      angle_sum[2] = angle_sum[1] + third_angle;
      for (int k = 0; k < fk3_pkg::LINKS; k++) begin
         phase[k]   = {angle_sum[k], {PAD{1'b0}}};
         rounded[k] = phase[k] + fk3_pkg::HALF_QUADRANT;
         quad[k]    = fk3_pkg::quadrant_type'(rounded[k][CW-1:CW-2]);
         // residual lands in [-1/8, 1/8) turn
         resid[k]   = phase[k] - {quad[k], {(CW-2){1'b0}}};
         lane_in[k].x = fk3_pkg::CORDIC_GAIN_Q30;
         lane_in[k].y = '0;
         lane_in[k].z = signed'(resid[k]);
         lane_in[k].q = quad[k];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff    <= lane_in;
         heading_ff <= angle_sum[2];
      end
   end

   assign out_valid   = valid_ff;
   assign out_lane    = lane_ff;
   assign out_heading = heading_ff;

`ifndef SYNTHESIS
   a_residual_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |->
         lane_ff[0].z >= -fk3_pkg::RESIDUAL_LIMIT && lane_ff[0].z < fk3_pkg::RESIDUAL_LIMIT &&
         lane_ff[1].z >= -fk3_pkg::RESIDUAL_LIMIT && lane_ff[1].z < fk3_pkg::RESIDUAL_LIMIT &&
         lane_ff[2].z >= -fk3_pkg::RESIDUAL_LIMIT && lane_ff[2].z < fk3_pkg::RESIDUAL_LIMIT)
      else $error("CORDIC seed outside one eighth turn");
`endif

endmodule

[sv/fk3_cordic.sv]
// Rotation-mode CORDIC pipeline, one micro-rotation per stage, three lanes side by side.
// Depends on fk3_pkg.
module fk3_cordic #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  fk3_pkg::lane_type      in_lane [fk3_pkg::LINKS],
   input  logic [ANGLE_WIDTH-1:0] in_heading,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fk3_pkg::lane_type      out_lane [fk3_pkg::LINKS],
   output logic [ANGLE_WIDTH-1:0] out_heading
);

   localparam int STEPS = fk3_pkg::CORDIC_STEPS;
   localparam int CW    = fk3_pkg::CORDIC_WIDTH;
   localparam fk3_pkg::cordic_word_type Z_RESIDUE_LIMIT = 32'sd1024;

   logic                   valid_ff [STEPS];
   fk3_pkg::lane_type      lane_ff [STEPS][fk3_pkg::LINKS];
   logic [ANGLE_WIDTH-1:0] heading_ff [STEPS];
   logic                   ready [STEPS+1];

   assign ready[STEPS] = out_ready;

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      fk3_pkg::lane_type      src [fk3_pkg::LINKS];
      fk3_pkg::lane_type      lane_in [fk3_pkg::LINKS];
      logic                   src_valid;
      logic [ANGLE_WIDTH-1:0] src_heading;

      if (s == 0) begin : g_first
         always_comb begin
            src         = in_lane;
            src_valid   = in_valid;
            src_heading = in_heading;
         end
      end else begin : g_next
         always_comb begin
            src         = lane_ff[s-1];
            src_valid   = valid_ff[s-1];
            src_heading = heading_ff[s-1];
         end
      end

      // rotate toward zero residual angle
      always_comb begin
         for (int l = 0; l < fk3_pkg::LINKS; l++) begin
            lane_in[l].q = src[l].q;
            if (!src[l].z[CW-1]) begin
               lane_in[l].x = src[l].x - (src[l].y >>> s);
               lane_in[l].y = src[l].y + (src[l].x >>> s);
               lane_in[l].z = src[l].z - fk3_pkg::arc_angle(s);
            end else begin
               lane_in[l].x = src[l].x + (src[l].y >>> s);
               lane_in[l].y = src[l].y - (src[l].x >>> s);
               lane_in[l].z = src[l].z + fk3_pkg::arc_angle(s);
            end
         end
      end

      assign ready[s] = !valid_ff[s] || ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[s] && src_valid) begin
            lane_ff[s]    <= lane_in;
            heading_ff[s] <= src_heading;
         end
      end
   end

   assign in_ready    = ready[0];
   assign out_valid   = valid_ff[STEPS-1];
   assign out_lane    = lane_ff[STEPS-1];
   assign out_heading = heading_ff[STEPS-1];

`ifndef SYNTHESIS
   a_converged: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STEPS-1] |->
         lane_ff[STEPS-1][0].z > -Z_RESIDUE_LIMIT && lane_ff[STEPS-1][0].z < Z_RESIDUE_LIMIT &&
         lane_ff[STEPS-1][1].z > -Z_RESIDUE_LIMIT && lane_ff[STEPS-1][1].z < Z_RESIDUE_LIMIT &&
         lane_ff[STEPS-1][2].z > -Z_RESIDUE_LIMIT && lane_ff[STEPS-1][2].z < Z_RESIDUE_LIMIT)
      else $error("CORDIC residual angle did not converge");
`endif

endmodule

[sv/fk3_combine.sv]
// Back end: quadrant restore, length multiply, x/y sums, rounding and saturation.
// Drives the result register. Depends on fk3_pkg.
module fk3_combine #(
   parameter int ANGLE_WIDTH  = 16,
   parameter int LENGTH_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  fk3_pkg::lane_type                       in_lane [fk3_pkg::LINKS],
   input  logic [ANGLE_WIDTH-1:0]                  in_heading,
   input  logic [LENGTH_WIDTH-1:0]                 link_length [fk3_pkg::LINKS],
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fk3_pkg::POS_WIDTH-1:0]    rsp_tool_x,
   output logic signed [fk3_pkg::POS_WIDTH-1:0]    rsp_tool_y,
   output logic signed [ANGLE_WIDTH-1:0]           rsp_tool_heading
);

   localparam int CW         = fk3_pkg::CORDIC_WIDTH;
   localparam int RW         = CW + 1;
   localparam int PROD_WIDTH = LENGTH_WIDTH + CW + 2;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int FB         = fk3_pkg::FRAC_BITS;
   localparam int VAL_WIDTH  = SUM_WIDTH - FB;
   localparam int SAT_WIDTH  =
      (VAL_WIDTH > fk3_pkg::POS_WIDTH ? VAL_WIDTH : fk3_pkg::POS_WIDTH) + 1;
   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
      {{(SUM_WIDTH-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
   localparam logic signed [SAT_WIDTH-1:0] SAT_MAX = SAT_WIDTH'(fk3_pkg::POS_MAX);
   localparam logic signed [SAT_WIDTH-1:0] SAT_MIN = SAT_WIDTH'(fk3_pkg::POS_MIN);

   // restore stage
   logic                   restore_valid_ff;
   logic signed [RW-1:0]   cos_ff [fk3_pkg::LINKS];
   logic signed [RW-1:0]   sin_ff [fk3_pkg::LINKS];
   logic signed [RW-1:0]   cos_in [fk3_pkg::LINKS];
   logic signed [RW-1:0]   sin_in [fk3_pkg::LINKS];
   logic signed [RW-1:0]   ext_x [fk3_pkg::LINKS];
   logic signed [RW-1:0]   ext_y [fk3_pkg::LINKS];
   logic [ANGLE_WIDTH-1:0] restore_heading_ff;
   logic                   restore_ready;

   // multiply stage
   logic                          mult_valid_ff;
   logic signed [PROD_WIDTH-1:0]  prod_x_ff [fk3_pkg::LINKS];
   logic signed [PROD_WIDTH-1:0]  prod_y_ff [fk3_pkg::LINKS];
   logic signed [LENGTH_WIDTH:0]  length_s [fk3_pkg::LINKS];
   logic [ANGLE_WIDTH-1:0]        mult_heading_ff;
   logic                          mult_ready;

   // sum stage
   logic                          sum_valid_ff;
   logic signed [SUM_WIDTH-1:0]   sum_x_ff;
   logic signed [SUM_WIDTH-1:0]   sum_y_ff;
   logic [ANGLE_WIDTH-1:0]        sum_heading_ff;
   logic                          sum_ready;

   // result register
   logic                                 rsp_valid_ff;
   logic signed [fk3_pkg::POS_WIDTH-1:0] rsp_tool_x_ff;
   logic signed [fk3_pkg::POS_WIDTH-1:0] rsp_tool_y_ff;
   logic signed [ANGLE_WIDTH-1:0]        rsp_tool_heading_ff;
   logic                                 out_ready;
   logic signed [SUM_WIDTH-1:0]          round_x;
   logic signed [SUM_WIDTH-1:0]          round_y;
   logic signed [SAT_WIDTH-1:0]          val_x;
   logic signed [SAT_WIDTH-1:0]          val_y;
   logic signed [fk3_pkg::POS_WIDTH-1:0] rsp_tool_x_in;
   logic signed [fk3_pkg::POS_WIDTH-1:0] rsp_tool_y_in;

   assign out_ready     = !rsp_valid_ff || !rsp_stall;
   assign sum_ready     = !sum_valid_ff || out_ready;
   assign mult_ready    = !mult_valid_ff || sum_ready;
   assign restore_ready = !restore_valid_ff || mult_ready;
   assign in_ready      = restore_ready;

   // turn the vector back by the quadrant removed up front
   always_comb begin
      for (int l = 0; l < fk3_pkg::LINKS; l++) begin
         ext_x[l] = RW'(in_lane[l].x);
         ext_y[l] = RW'(in_lane[l].y);
         case (in_lane[l].q)
            fk3_pkg::QUAD_EAST: begin
               cos_in[l] = ext_x[l];
               sin_in[l] = ext_y[l];
            end
            fk3_pkg::QUAD_NORTH: begin
               cos_in[l] = -ext_y[l];
               sin_in[l] = ext_x[l];
            end
            fk3_pkg::QUAD_WEST: begin
               cos_in[l] = -ext_x[l];
               sin_in[l] = -ext_y[l];
            end
            default: begin
               cos_in[l] = ext_y[l];
               sin_in[l] = -ext_x[l];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restore_valid_ff <= 1'b0;
         mult_valid_ff    <= 1'b0;
         sum_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (restore_ready) begin
            restore_valid_ff <= in_valid;
         end
         if (mult_ready) begin
            mult_valid_ff <= restore_valid_ff;
         end
         if (sum_ready) begin
            sum_valid_ff <= mult_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (restore_ready && in_valid) begin
         cos_ff             <= cos_in;
         sin_ff             <= sin_in;
         restore_heading_ff <= in_heading;
      end
   end

   always_comb begin
      for (int l = 0; l < fk3_pkg::LINKS; l++) begin
         length_s[l] = signed'({1'b0, link_length[l]});
      end
   end

   always_ff @(posedge clock) begin
      if (mult_ready && restore_valid_ff) begin
         for (int l = 0; l < fk3_pkg::LINKS; l++) begin
            prod_x_ff[l] <= PROD_WIDTH'(cos_ff[l]) * PROD_WIDTH'(length_s[l]);
            prod_y_ff[l] <= PROD_WIDTH'(sin_ff[l]) * PROD_WIDTH'(length_s[l]);
         end
         mult_heading_ff <= restore_heading_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && mult_valid_ff) begin
         sum_x_ff <= SUM_WIDTH'(prod_x_ff[0]) + SUM_WIDTH'(prod_x_ff[1])
                   + SUM_WIDTH'(prod_x_ff[2]);
         sum_y_ff <= SUM_WIDTH'(prod_y_ff[0]) + SUM_WIDTH'(prod_y_ff[1])
                   + SUM_WIDTH'(prod_y_ff[2]);
         sum_heading_ff <= mult_heading_ff;
      end
   end

   // round half up to whole length units, then clamp to the field range
   always_comb begin
      round_x = sum_x_ff + ROUND_HALF;
      round_y = sum_y_ff + ROUND_HALF;
      val_x   = SAT_WIDTH'(signed'(round_x[SUM_WIDTH-1:FB]));
      val_y   = SAT_WIDTH'(signed'(round_y[SUM_WIDTH-1:FB]));
      if (val_x > SAT_MAX) begin
         rsp_tool_x_in = SAT_MAX[fk3_pkg::POS_WIDTH-1:0];
      end else if (val_x < SAT_MIN) begin
         rsp_tool_x_in = SAT_MIN[fk3_pkg::POS_WIDTH-1:0];
      end else begin
         rsp_tool_x_in = val_x[fk3_pkg::POS_WIDTH-1:0];
      end
      if (val_y > SAT_MAX) begin
         rsp_tool_y_in = SAT_MAX[fk3_pkg::POS_WIDTH-1:0];
      end else if (val_y < SAT_MIN) begin
         rsp_tool_y_in = SAT_MIN[fk3_pkg::POS_WIDTH-1:0];
      end else begin
         rsp_tool_y_in = val_y[fk3_pkg::POS_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && sum_valid_ff) begin
         rsp_tool_x_ff       <= rsp_tool_x_in;
         rsp_tool_y_ff       <= rsp_tool_y_in;
         rsp_tool_heading_ff <= signed'(sum_heading_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tool_x       = rsp_tool_x_ff;
   assign rsp_tool_y       = rsp_tool_y_ff;
   assign rsp_tool_heading = rsp_tool_heading_ff;

`ifndef SYNTHESIS
   a_sum_reaches_output: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && out_ready |=> rsp_valid_ff)
      else $error("finished sum dropped before the result register");
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && sum_valid_ff && mult_valid_ff |=>
         sum_valid_ff && mult_valid_ff)
      else $error("stalled back end lost a beat");
`endif

endmodule
